// ===== rtl/set_assoc_cache_tag_lru_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SET_ASSOC_CACHE_TAG_LRU_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LRU_CORE_ASSERT_SVH

// Same-cycle implication, reset disables the check.
`define SACL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset disables the check.
`define SACL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Delayed implication, reset disables the check.
`define SACL_ASSERT_TWO(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) else $error(msg);

`endif

// ===== rtl/sacl_pkg.sv =====
`timescale 1ns / 1ps
package sacl_pkg;

   // Fixed address split and field widths
   localparam int ADDR_BITS     = 32;
   localparam int OFFSET_BITS   = 6;
   localparam int SET_BITS      = 7;
   localparam int NUM_SETS      = 1 << SET_BITS;
   localparam int TAG_W         = ADDR_BITS - OFFSET_BITS - SET_BITS;
   localparam int OUT_WAY_W     = 2;
   localparam int CNT_W         = 32;
   localparam int DEF_NUM_WAYS  = 4;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic lookup;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

// ===== rtl/sacl_ctrl.sv =====
`timescale 1ns / 1ps
module sacl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sacl_pkg::dp_status_type status,
   output sacl_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);
   import sacl_pkg::*;

   state_type state_ff, state_in;

   // Sequence clear pass, then one lookup per transaction
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive datapath commands
   always_comb begin
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.load   = (state_ff == ST_IDLE) && start;
      cmd.lookup = (state_ff == ST_LOOKUP);
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/sacl_datapath.sv =====
`timescale 1ns / 1ps
module sacl_datapath #(
   parameter int NUM_WAYS = sacl_pkg::DEF_NUM_WAYS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sacl_pkg::ctrl_cmd_type             cmd,
   input  logic [sacl_pkg::ADDR_BITS-1:0]     req_address,
   output sacl_pkg::dp_status_type            status,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [sacl_pkg::SET_BITS-1:0]      rsp_set_index,
   output logic [sacl_pkg::OUT_WAY_W-1:0]     rsp_way,
   output logic [sacl_pkg::CNT_W-1:0]         rsp_hit_count,
   output logic [sacl_pkg::CNT_W-1:0]         rsp_miss_count
);
   import sacl_pkg::*;

   localparam int WAY_W  = $clog2(NUM_WAYS);
   localparam int RANK_W = $clog2(NUM_WAYS);

   // Directory memories, one row per set
   logic [NUM_WAYS-1:0]             mem_valid_ff [NUM_SETS];
   logic [NUM_WAYS-1:0][TAG_W-1:0]  mem_tag_ff   [NUM_SETS];
   logic [NUM_WAYS-1:0][RANK_W-1:0] mem_rank_ff  [NUM_SETS];

   logic [NUM_WAYS-1:0]             rd_valid_ff;
   logic [NUM_WAYS-1:0][TAG_W-1:0]  rd_tag_ff;
   logic [NUM_WAYS-1:0][RANK_W-1:0] rd_rank_ff;

   logic [SET_BITS-1:0] set_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [SET_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]    hits_ff, hits_in;
   logic [CNT_W-1:0]    misses_ff, misses_in;

   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [SET_BITS-1:0] rsp_set_ff;
   logic [OUT_WAY_W-1:0] rsp_way_ff;
   logic [CNT_W-1:0]    rsp_hits_ff;
   logic [CNT_W-1:0]    rsp_misses_ff;

   logic                            hit;
   logic [WAY_W-1:0]                hit_way;
   logic [WAY_W-1:0]                victim;
   logic [WAY_W-1:0]                way_sel;
   logic [NUM_WAYS-1:0]             wr_valid;
   logic [NUM_WAYS-1:0][TAG_W-1:0]  wr_tag;
   logic [NUM_WAYS-1:0][RANK_W-1:0] wr_rank;
   logic                            wr_en;
   logic [SET_BITS-1:0]             wr_addr;

   // Search the set for a valid matching tag, lowest way first
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!hit && rd_valid_ff[w] && (rd_tag_ff[w] == tag_ff)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
   end

   // Pick victim: lowest invalid way, else lowest oldest way
   always_comb begin
      logic              have_inv;
      logic              have_old;
      logic [RANK_W-1:0] oldest;
      have_inv = 1'b0;
      have_old = 1'b0;
      oldest   = '0;
      victim   = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!have_inv) begin
            if (!rd_valid_ff[w]) begin
               have_inv = 1'b1;
               victim   = WAY_W'(w);
            end else if (!have_old || (rd_rank_ff[w] > oldest)) begin
               have_old = 1'b1;
               oldest   = rd_rank_ff[w];
               victim   = WAY_W'(w);
            end
         end
      end
   end

   assign way_sel = hit ? hit_way : victim;

   // Touch the selected way: younger valid ways age by one
   always_comb begin
      logic [RANK_W:0] old_rank;
      old_rank = rd_valid_ff[way_sel] ? {1'b0, rd_rank_ff[way_sel]}
                                      : (RANK_W+1)'(NUM_WAYS);
      wr_valid = rd_valid_ff;
      wr_tag   = rd_tag_ff;
      wr_rank  = rd_rank_ff;
      for (int v = 0; v < NUM_WAYS; v++) begin
         if (WAY_W'(v) == way_sel) begin
            wr_rank[v] = '0;
         end else if (rd_valid_ff[v] && ({1'b0, rd_rank_ff[v]} < old_rank)) begin
            wr_rank[v] = rd_rank_ff[v] + RANK_W'(1);
         end
      end
      if (!hit) begin
         wr_valid[way_sel] = 1'b1;
         wr_tag[way_sel]   = tag_ff;
      end
   end

   // Write back on lookup, or clear one row per cycle after reset
   assign wr_en   = cmd.clear || cmd.lookup;
   assign wr_addr = cmd.clear ? clr_cnt_ff : set_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_valid_ff[wr_addr] <= cmd.clear ? '0 : wr_valid;
         mem_tag_ff[wr_addr]   <= cmd.clear ? '0 : wr_tag;
         mem_rank_ff[wr_addr]  <= cmd.clear ? '0 : wr_rank;
      end
      if (cmd.load) begin
         rd_valid_ff <= mem_valid_ff[req_address[OFFSET_BITS +: SET_BITS]];
         rd_tag_ff   <= mem_tag_ff[req_address[OFFSET_BITS +: SET_BITS]];
         rd_rank_ff  <= mem_rank_ff[req_address[OFFSET_BITS +: SET_BITS]];
      end
   end

   // Capture address fields of the transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         set_ff <= req_address[OFFSET_BITS +: SET_BITS];
         tag_ff <= req_address[ADDR_BITS-1 -: TAG_W];
      end
   end

   // Advance clear counter and saturating hit/miss totals
   always_comb begin
      clr_cnt_in = cmd.clear ? clr_cnt_ff + SET_BITS'(1) : clr_cnt_ff;
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      if (cmd.lookup) begin
         if (hit && !(&hits_ff))        hits_in   = hits_ff + CNT_W'(1);
         if (!hit && !(&misses_ff))     misses_in = misses_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= cmd.lookup;
      end
   end

   // Register the result
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rsp_hit_ff    <= hit;
         rsp_set_ff    <= set_ff;
         rsp_way_ff    <= OUT_WAY_W'(way_sel);
         rsp_hits_ff   <= hits_in;
         rsp_misses_ff <= misses_in;
      end
   end

   assign status.clear_last = &clr_cnt_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_set_index  = rsp_set_ff;
   assign rsp_way        = rsp_way_ff;
   assign rsp_hit_count  = rsp_hits_ff;
   assign rsp_miss_count = rsp_misses_ff;

endmodule

// ===== rtl/set_assoc_cache_tag_lru_core.sv =====
`timescale 1ns / 1ps
// Tag directory of a set-associative cache with true LRU replacement. A
// transaction is accepted on a clock edge with start high and busy low; its
// result appears on the rsp_ ports for exactly one cycle, marked by rsp_valid,
// and must be taken then since the receiver cannot stall. A transaction first
// reads the set's directory row, then compares the tags, picks the way and
// writes the row back; busy stays high only during the compare and write-back,
// so a new transaction can start as soon as busy falls, in the same cycle its
// predecessor's result is shown. After reset a clearing pass walks the
// directory one set per cycle with busy high.
module set_assoc_cache_tag_lru_core #(
   parameter int NUM_WAYS = sacl_pkg::DEF_NUM_WAYS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [sacl_pkg::ADDR_BITS-1:0] req_address,
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic [sacl_pkg::SET_BITS-1:0]  rsp_set_index,
   output logic [sacl_pkg::OUT_WAY_W-1:0] rsp_way,
   output logic [sacl_pkg::CNT_W-1:0]     rsp_hit_count,
   output logic [sacl_pkg::CNT_W-1:0]     rsp_miss_count
);
   import sacl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sacl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   sacl_datapath #(
      .NUM_WAYS (NUM_WAYS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_address    (req_address),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_set_index  (rsp_set_index),
      .rsp_way        (rsp_way),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_miss_count (rsp_miss_count)
   );

endmodule

// ===== rtl/sacl_checker.sv =====
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lru_core_assert.svh"
module sacl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic                           rsp_hit,
   input logic [sacl_pkg::CNT_W-1:0]     rsp_hit_count,
   input logic [sacl_pkg::CNT_W-1:0]     rsp_miss_count
);

   // A transaction is followed by busy, then by exactly one result strobe
   `SACL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy low after accept")
   `SACL_ASSERT_TWO(a_accept_rsp, clock, reset, start && !busy, rsp_valid, "no result after accept")
   `SACL_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe repeated")

   // A result carries a nonzero total for its own kind
   `SACL_ASSERT_NOW(a_rsp_count, clock, reset, rsp_valid, (rsp_hit ? (rsp_hit_count != '0) : (rsp_miss_count != '0)), "zero total on result")

endmodule

bind set_assoc_cache_tag_lru_core sacl_checker u_checker (.*);

// ===== tb/sv/set_assoc_cache_tag_lru_core_tb.sv =====
`timescale 1ns / 1ps
module set_assoc_cache_tag_lru_core_tb;

   import sacl_pkg::*;

   localparam int WAYS        = DEF_NUM_WAYS;
   localparam int RAND_ITEMS  = 1000;
   localparam int TAG_POOL    = 6;
   localparam int SET_POOL    = 8;
   localparam int TAIL_CYCLES = 8;

   // One lookup result as seen on the rsp_ ports
   typedef struct packed {
      logic                 hit;
      logic [SET_BITS-1:0]  set_index;
      logic [OUT_WAY_W-1:0] way;
      logic [CNT_W-1:0]     hit_count;
      logic [CNT_W-1:0]     miss_count;
   } lookup_rsp_type;

   // Directed access, with a hand-written expectation where fixed is set
   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      bit                   fixed;
      lookup_rsp_type       rsp;
   } access_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [ADDR_BITS-1:0] req_address;
   logic                 rsp_valid;
   logic                 rsp_hit;
   logic [SET_BITS-1:0]  rsp_set_index;
   logic [OUT_WAY_W-1:0] rsp_way;
   logic [CNT_W-1:0]     rsp_hit_count;
   logic [CNT_W-1:0]     rsp_miss_count;

   // Directory mirror: valid bits, tags and LRU ages per set and way
   bit                   dir_valid [NUM_SETS][WAYS];
   logic [TAG_W-1:0]     dir_tag   [NUM_SETS][WAYS];
   int                   dir_age   [NUM_SETS][WAYS];
   logic [CNT_W-1:0]     hits_seen;
   logic [CNT_W-1:0]     misses_seen;

   lookup_rsp_type       pending_rsp[$];
   access_row_type       access_rows[$];
   lookup_rsp_type       got_rsp;
   lookup_rsp_type       want_rsp;
   int                   mismatches = 0;
   int                   accesses_sent = 0;
   int                   results_checked = 0;
   int                   hits_observed = 0;

   set_assoc_cache_tag_lru_core #(
      .NUM_WAYS(WAYS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_address    (req_address),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_set_index  (rsp_set_index),
      .rsp_way        (rsp_way),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_miss_count (rsp_miss_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Move way w of set s to most recent; younger valid ways age by one
   function automatic void promote_way(input int s, input int w);
      int old_age;
      old_age = dir_valid[s][w] ? dir_age[s][w] : WAYS;
      for (int v = 0; v < WAYS; v++) begin
         if (v != w && dir_valid[s][v] && dir_age[s][v] < old_age)
            dir_age[s][v]++;
      end
      dir_age[s][w] = 0;
   endfunction

   // Look up one address in the mirror, update it and return the result
   function automatic lookup_rsp_type predict_lookup(input logic [ADDR_BITS-1:0] addr);
      lookup_rsp_type   r;
      int               s;
      int               victim;
      int               oldest;
      bit               found;
      logic [TAG_W-1:0] t;
      s      = int'(addr[OFFSET_BITS +: SET_BITS]);
      t      = addr[ADDR_BITS-1 -: TAG_W];
      found  = 1'b0;
      victim = WAYS;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && dir_valid[s][w] && dir_tag[s][w] == t) begin
            found  = 1'b1;
            victim = w;
         end
      end
      if (found) begin
         if (hits_seen != '1) hits_seen++;
         promote_way(s, victim);
      end else begin
         if (misses_seen != '1) misses_seen++;
         // take the lowest invalid way, else the oldest (lowest on a tie)
         oldest = 0;
         for (int w = 0; w < WAYS; w++) begin
            if (!found) begin
               if (!dir_valid[s][w]) begin
                  victim = w;
                  found  = 1'b1;
               end else if (victim == WAYS || dir_age[s][w] > oldest) begin
                  oldest = dir_age[s][w];
                  victim = w;
               end
            end
         end
         promote_way(s, victim);
         dir_valid[s][victim] = 1'b1;
         dir_tag[s][victim]   = t;
         found = 1'b0;
      end
      r.hit        = found;
      r.set_index  = SET_BITS'(s);
      r.way        = OUT_WAY_W'(victim);
      r.hit_count  = hits_seen;
      r.miss_count = misses_seen;
      return r;
   endfunction

   function automatic access_row_type row(input logic [ADDR_BITS-1:0] addr, input bit fixed,
                                          input bit hit, input int s, input int w,
                                          input int hits, input int misses);
      access_row_type r;
      r.addr           = addr;
      r.fixed          = fixed;
      r.rsp.hit        = hit;
      r.rsp.set_index  = SET_BITS'(s);
      r.rsp.way        = OUT_WAY_W'(w);
      r.rsp.hit_count  = CNT_W'(hits);
      r.rsp.miss_count = CNT_W'(misses);
      return r;
   endfunction

   // Present one transaction, hold it until accepted, then queue its result
   task automatic issue(input logic [ADDR_BITS-1:0] addr, input bit fixed,
                        input lookup_rsp_type fixed_rsp);
      lookup_rsp_type p;
      start       <= 1'b1;
      req_address <= addr;
      do @(posedge clock); while (busy);
      p = predict_lookup(addr);
      pending_rsp.push_back(fixed ? fixed_rsp : p);
      accesses_sent++;
   endtask

   // Check every result against the oldest pending expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         got_rsp = '{rsp_hit, rsp_set_index, rsp_way, rsp_hit_count, rsp_miss_count};
         hits_observed += rsp_hit;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR %0t: result with nothing pending: hit=%0b set=%0d way=%0d",
                        $realtime, rsp_hit, rsp_set_index, rsp_way);
         end else begin
            want_rsp = pending_rsp.pop_front();
            results_checked++;
            if (got_rsp !== want_rsp) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR %0t: result %0d mismatch", $realtime, results_checked);
                  $display("   expected hit=%0b set=%0d way=%0d hits=%0d misses=%0d",
                           want_rsp.hit, want_rsp.set_index, want_rsp.way,
                           want_rsp.hit_count, want_rsp.miss_count);
                  $display("   actual   hit=%0b set=%0d way=%0d hits=%0d misses=%0d",
                           got_rsp.hit, got_rsp.set_index, got_rsp.way,
                           got_rsp.hit_count, got_rsp.miss_count);
               end
            end
         end
      end
   end

   // Stimulus: directed table, then bursty random traffic over a small working set
   initial begin
      logic [TAG_W-1:0]     tag_pool [TAG_POOL];
      logic [SET_BITS-1:0]  set_pool [SET_POOL];
      logic [ADDR_BITS-1:0] last_addr;
      logic [ADDR_BITS-1:0] addr;
      int                   n;
      int                   burst;
      int                   gap;
      int                   pick;
      bit                   drain_now;
      bit                   drained;

      reset       <= 1'b1;
      start       <= 1'b0;
      req_address <= '0;
      hits_seen   = '0;
      misses_seen = '0;
      for (int s = 0; s < NUM_SETS; s++)
         for (int w = 0; w < WAYS; w++) begin
            dir_valid[s][w] = 1'b0;
            dir_tag[s][w]   = '0;
            dir_age[s][w]   = 0;
         end

      // cold misses, line-offset hits, fill of set 0 and LRU eviction
      access_rows.push_back(row(32'h0000_0000, 1, 0, 0,   0, 0, 1));
      access_rows.push_back(row(32'hFFFF_FFFF, 1, 0, 127, 0, 0, 2));
      access_rows.push_back(row(32'h0000_003F, 1, 1, 0,   0, 1, 2));
      access_rows.push_back(row(32'hFFFF_FFC0, 1, 1, 127, 0, 2, 2));
      access_rows.push_back(row(32'h0000_2000, 1, 0, 0,   1, 2, 3));
      access_rows.push_back(row(32'h0000_4000, 1, 0, 0,   2, 2, 4));
      access_rows.push_back(row(32'h0000_6000, 1, 0, 0,   3, 2, 5));
      access_rows.push_back(row(32'h0000_8000, 1, 0, 0,   0, 2, 6));
      // reorder ages by a hit, then evict again and repeat same lines back to back
      access_rows.push_back(row(32'h0000_2010, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'h0000_0000, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'h0000_6000, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'h0000_6000, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'h0000_8040, 0, 0, 0, 0, 0, 0));
      // tag extremes and alternating bit patterns
      access_rows.push_back(row(32'h7FFF_E000, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'h8000_0000, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'hFFFF_E03F, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'h0000_1FC0, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'h5555_5555, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'h0000_2000, 0, 0, 0, 0, 0, 0));
      access_rows.push_back(row(32'h0000_4000, 0, 0, 0, 0, 0, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, back to back; the first one waits out the clearing pass
      foreach (access_rows[i])
         issue(access_rows[i].addr, access_rows[i].fixed, access_rows[i].rsp);

      last_addr = 32'h0000_4000;
      n         = 0;
      drained   = 1'b0;
      while (n < RAND_ITEMS) begin
         // refresh the working set now and then so new sets and tags get used
         if (n % 250 == 0) begin
            foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
            foreach (set_pool[i]) set_pool[i] = SET_BITS'($urandom);
         end
         burst = $urandom_range(1, 24);
         for (int b = 0; b < burst && n < RAND_ITEMS; b++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
               addr = {tag_pool[$urandom_range(0, TAG_POOL-1)],
                       set_pool[$urandom_range(0, SET_POOL-1)], OFFSET_BITS'($urandom)};
            else if (pick < 85)
               addr = {last_addr[ADDR_BITS-1:OFFSET_BITS], OFFSET_BITS'($urandom)};
            else if (pick < 92)
               addr = {tag_pool[$urandom_range(0, TAG_POOL-1)],
                       last_addr[OFFSET_BITS +: SET_BITS], OFFSET_BITS'($urandom)};
            else
               addr = $urandom;
            issue(addr, 1'b0, '0);
            last_addr = addr;
            n++;
         end
         gap       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         drain_now = !drained && n >= RAND_ITEMS / 2;
         if (gap != 0 || drain_now) begin
            start       <= 1'b0;
            req_address <= $urandom;
         end
         repeat (gap) @(posedge clock);
         // hold off once until the block has returned everything
         if (drain_now) begin
            while (pending_rsp.size() != 0) @(posedge clock);
            drained = 1'b1;
         end
      end

      if (gap == 0 && !drain_now) start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d accesses (%0d directed) with %0d results checked,",
               accesses_sent, access_rows.size(), results_checked);
      $display("%0d of them hits, across bursty traffic over random working sets",
               hits_observed);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2_000_000;
      $display("Timeout with %0d results still pending", pending_rsp.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
